@@ rtl/core/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Request types, round constants, the initial hash and the round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  // Classification of an incoming request.
  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } req_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha_front.sv @@
// ----------------------------------------------------------------------------
// SHA-256 request front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
  import sha_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output logic            req_valid,
  output req_t            req,
  input  wire logic       req_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  req_t             incoming;

  assign item_stall = (count == CNT_W'(DEPTH));
  assign req_valid  = (count != '0);
  assign req        = queue[rd_ptr];
  assign push       = item_valid && !item_stall;
  assign pop        = req_pop && req_valid;

  always_comb begin
    incoming.kind = op ? KIND_FINISH : KIND_BYTE;
    incoming.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> req_valid)
    else $error("back end popped an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sha_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes, pads the message, runs the rounds and returns the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_engine
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire req_t        req,
  output logic             req_pop,
  output logic             digest_valid,
  input  wire logic        digest_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  state_t      state;
  state_t      ret_state;
  logic [5:0]  pos;
  logic [23:0] acc;
  word_t       win [16];
  logic [63:0] bits;
  logic        pad_first;
  logic [2:0]  len_idx;
  logic [5:0]  round;
  word_t       v [8];
  word_t       cv [8];
  logic [2:0]  out_idx;

  logic        push_en;
  logic [7:0]  push_byte;
  word_t       t1;
  word_t       t2;
  word_t       w_new;

  always_comb begin
    push_en   = 1'b0;
    push_byte = '0;
    req_pop   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          if (req.kind == KIND_BYTE) begin
            push_en   = 1'b1;
            push_byte = req.data;
          end
        end
      end
      ST_PAD: begin
        push_en   = 1'b1;
        push_byte = pad_first ? PAD_BYTE : 8'd0;
      end
      ST_LEN: begin
        push_en   = 1'b1;
        push_byte = bits[{~len_idx, 3'b000} +: 8];
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    t1 = v[7] + big_sigma1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[round] + win[0];
    t2 = big_sigma0(v[0]) + majority(v[0], v[1], v[2]);
    w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret_state    <= ST_IDLE;
      pos          <= '0;
      bits         <= '0;
      pad_first    <= 1'b0;
      len_idx      <= '0;
      round        <= '0;
      out_idx      <= '0;
      cv           <= INIT_HASH;
      digest_valid <= 1'b0;
    end else begin
      // In the output state the digest register is refilled below instead.
      if (digest_valid && !digest_stall && state != ST_OUT) begin
        digest_valid <= 1'b0;
      end

      // Byte packing: every fourth byte completes a word that enters the window.
      if (push_en) begin
        if (pos[1:0] == 2'b11) begin
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= {acc, push_byte};
        end else begin
          acc <= {acc[15:0], push_byte};
        end
        pos <= pos + 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (req.kind == KIND_BYTE) begin
              bits <= bits + 64'd8;
              if (pos == 6'd63) begin
                state     <= ST_ROUND;
                ret_state <= ST_IDLE;
                v         <= cv;
                round     <= '0;
              end
            end else begin
              state     <= ST_PAD;
              pad_first <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (pos == 6'd63) begin
            state     <= ST_ROUND;
            ret_state <= ST_PAD;
            v         <= cv;
            round     <= '0;
          end else if (pos == 6'd55) begin
            state   <= ST_LEN;
            len_idx <= '0;
          end
        end
        ST_LEN: begin
          len_idx <= len_idx + 1'b1;
          if (len_idx == 3'd7) begin
            state     <= ST_ROUND;
            ret_state <= ST_OUT;
            v         <= cv;
            round     <= '0;
          end
        end
        ST_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_new;
          round   <= round + 1'b1;
          if (round == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            cv[i] <= cv[i] + v[i];
          end
          out_idx <= '0;
          state   <= ret_state;
        end
        ST_OUT: begin
          if (!digest_valid || !digest_stall) begin
            digest_valid <= 1'b1;
            digest_word  <= cv[out_idx];
            word_index   <= out_idx;
            last         <= (out_idx == 3'd7);
            out_idx      <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              cv    <= INIT_HASH;
              bits  <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> state == ST_IDLE)
    else $error("request taken outside idle");

  a_last_on_seventh: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && last) |-> word_index == 3'd7)
    else $error("last flag on wrong digest word");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD |-> $past(state) == ST_ROUND && $past(round) == 6'd63)
    else $error("fold without a full set of rounds");

  a_len_position: assert property (@(posedge clk) disable iff (rst)
    state == ST_LEN |-> pos[5:3] == 3'b111 && pos[2:0] == len_idx)
    else $error("length bytes out of place");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sha256_message_digest.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-stream SHA-256 with padding and an eight-word digest output.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    op, data_byte
// digest    out        digest_valid / digest_stall digest_word, word_index, last
//
// A message byte is taken by the back end while it is idle. Every 64th byte
// starts the compression, one round per cycle: 64 rounds, then a fold of the
// result into the chaining value, all done by the single round unit; no more
// bytes are taken until the fold is done.
// A finish request pads one byte per cycle (pad and length bytes fill one or
// two blocks, each compressed as above), then delivers eight digest words, one
// per cycle unless digest_stall holds them.
// Reset (rst, synchronous) empties the request queue, clears the byte and bit
// counts and loads the standard initial hash.
// The request queue keeps item_stall low while the back end is busy, until it
// fills; a stalled digest word stays in the output register.
//
`default_nettype none

module sha256_message_digest
  import sha_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             digest_valid,
  input  wire logic        digest_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);

  // Requests travel from the classifying front end to the engine through
  // the queue inside the front end.
  logic req_valid;
  req_t req;
  logic req_pop;

  sha_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .data_byte  (data_byte),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop)
  );

  // The engine owns the block window, the counts, the chaining value and the
  // output register.
  sha_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req          (req),
    .req_pop      (req_pop),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last         (last)
  );

endmodule

`default_nettype wire
